// ===== rtl/core/mcgs_pkg.sv =====
// Shared constants, codes and helpers of the max-cut Gray-code search unit.
// No dependencies; imported by max_cut_gray_code_search_unit.
package mcgs_pkg;

   localparam int ROW_W       = 32;
   localparam int DEG_W       = 6;
   localparam int CUT_W       = 40;
   localparam int MAX_W       = 9;
   localparam int COUNT_W     = 6;
   localparam int SLACK_W     = 5;
   localparam int SLACK_SPAN  = 32;
   localparam int VIDX_W      = 5;
   localparam int MAX_POOL    = 63;
   localparam int MAX_CUT_SAT = 511;

   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 6;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 48;

   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_LIMIT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLACK_LIMIT  = 2'd2;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_START = 1'b1;

   localparam logic KIND_CUT     = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   function automatic logic [DEG_W-1:0] ones32(input logic [ROW_W-1:0] x);
      logic [DEG_W-1:0] acc;
      acc = '0;
      for (int b = 0; b < ROW_W; b++) begin
         acc = acc + DEG_W'(x[b]);
      end
      return acc;
   endfunction

endpackage

// ===== rtl/core/mcgs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used by max_cut_gray_code_search_unit for adjacency rows.
module mcgs_ram #(
   parameter int WIDTH = 38,
   parameter int DEPTH = 32,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/max_cut_gray_code_search_unit.sv =====
// Max-cut search by exhaustive Gray-code enumeration. A load beat (tuser 0) writes one
// adjacency row and its degree into the row RAM, one beat per cycle while the unit is idle. A
// start beat (tuser 1) occupies the unit: with n vertices in use it makes a walk of
// 2^(n-1)-1 Gray steps to find the maximum cut, a second walk of as many steps that counts
// cuts per deficit, a scan over those counts from deficit 0 up to slack_limit, and a third walk
// that stops once pool_limit cuts are collected; each walk runs through the issue, read and cut
// stages, the row RAM read of one Gray step overlapping the running-cut update of the last. Each
// collected cut leaves as a result beat while the third walk runs and a full, unread result
// register holds the walk; the summary beat, marked tlast, follows. Depends on mcgs_pkg and
// mcgs_ram.
module max_cut_gray_code_search_unit #(
   parameter int MAX_VERTICES = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [mcgs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mcgs_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // vertex_index [4:0], row_bits [36:5], zero [39:37]
   input  logic [mcgs_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // req_type [0]
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // cut_mask [31:0], max_cut [40:32], tight_count [46:41], zero [47]
   output logic [mcgs_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // result_kind [0]
   output logic                                rsp_tuser,
   output logic                                rsp_tlast
);

   import mcgs_pkg::*;

   localparam int VA_W  = $clog2(MAX_VERTICES);
   localparam int CNT_W = MAX_VERTICES - 1;
   localparam int RAM_W = ROW_W + DEG_W;
   localparam logic [CSR_DATA_W-1:0] NV_MAX = CSR_DATA_W'(MAX_VERTICES);
   localparam logic signed [CUT_W-1:0] SAT_LIMIT = CUT_W'(MAX_CUT_SAT);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MAX,
      S_HIST,
      S_SCAN,
      S_COLLECT,
      S_SUMMARY
   } state_type;

   state_type                 state_ff, state_in;
   logic [CSR_DATA_W-1:0]     vcount_ff, vcount_in;
   logic [COUNT_W-1:0]        pool_ff, pool_in;
   logic [SLACK_W-1:0]        slack_ff, slack_in;
   logic                      valid_ff [MAX_VERTICES];
   logic                      valid_in [MAX_VERTICES];
   logic                      issue_active_ff, issue_active_in;
   logic [CNT_W-1:0]          issue_ctr_ff, issue_ctr_in;
   logic                      b_valid_ff, b_valid_in;
   logic                      b_last_ff, b_last_in;
   logic [VA_W-1:0]           b_vtx_ff, b_vtx_in;
   logic                      rd_valid_ff, rd_valid_in;
   logic [MAX_VERTICES-1:0]   sides_ff, sides_in;
   logic signed [CUT_W-1:0]   cut_ff, cut_in;
   logic                      c_valid_ff, c_valid_in;
   logic                      c_last_ff, c_last_in;
   logic signed [CUT_W-1:0]   best_ff, best_in;
   logic [COUNT_W-1:0]        hist_ff [SLACK_SPAN];
   logic [COUNT_W-1:0]        hist_in [SLACK_SPAN];
   logic [SLACK_W-1:0]        scan_ff, scan_in;
   logic [COUNT_W-1:0]        acc_ff, acc_in;
   logic [SLACK_W-1:0]        sel_slack_ff, sel_slack_in;
   logic [COUNT_W-1:0]        cnt_ff, cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_kind_ff, rsp_kind_in;
   logic [ROW_W-1:0]          rsp_mask_ff, rsp_mask_in;
   logic [MAX_W-1:0]          rsp_max_ff, rsp_max_in;
   logic [COUNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      ram_wr_en;
   logic [VA_W-1:0]           ram_wr_addr;
   logic [RAM_W-1:0]          ram_wr_data;
   logic                      ram_rd_en;
   logic [RAM_W-1:0]          ram_rd_data;

   logic [CSR_DATA_W-1:0]     n_eff;
   logic [COUNT_W-1:0]        pool_k;
   logic [CNT_W-1:0]          step_mask;
   logic                      issue_last;
   logic [CNT_W-1:0]          issue_iso;
   logic [VA_W-1:0]           v_sel;
   logic [ROW_W-1:0]          row_b;
   logic [DEG_W-1:0]          deg_b;
   logic [DEG_W-1:0]          inter_b;
   logic signed [7:0]         step_delta;
   logic signed [CUT_W-1:0]   delta_ext;
   logic signed [CUT_W-1:0]   gap;
   logic signed [CUT_W-1:0]   lim_w;
   logic signed [CUT_W-1:0]   sel_w;
   logic                      in_lim;
   logic                      hit;
   logic                      out_free;
   logic                      walking;
   logic                      stall;
   logic [COUNT_W:0]          scan_sum;
   logic [COUNT_W-1:0]        cnt_next;
   logic [VIDX_W-1:0]         req_vidx;
   logic [ROW_W-1:0]          req_row;
   logic [MAX_W-1:0]          best_sat;

   mcgs_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_VERTICES)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (v_sel),
      .rd_data (ram_rd_data)
   );

   assign req_vidx = req_tdata[VIDX_W-1:0];
   assign req_row  = req_tdata[VIDX_W+ROW_W-1:VIDX_W];

   always_comb begin
      priority if (vcount_ff < CSR_DATA_W'(2)) begin
         n_eff = CSR_DATA_W'(2);
      end else if (vcount_ff > NV_MAX) begin
         n_eff = NV_MAX;
      end else begin
         n_eff = vcount_ff;
      end
      priority if (pool_ff == '0) begin
         pool_k = COUNT_W'(1);
      end else if (pool_ff > COUNT_W'(MAX_POOL)) begin
         pool_k = COUNT_W'(MAX_POOL);
      end else begin
         pool_k = pool_ff;
      end
   end

   always_comb begin
      for (int b = 0; b < CNT_W; b++) begin
         step_mask[b] = (CSR_DATA_W'(b) < (n_eff - CSR_DATA_W'(1)));
      end
      issue_last = &(issue_ctr_ff | ~step_mask);
      issue_iso  = issue_ctr_ff & (~issue_ctr_ff + CNT_W'(1));
      v_sel      = '0;
      for (int b = 0; b < CNT_W; b++) begin
         if (issue_iso[b]) begin
            v_sel = v_sel | VA_W'(b + 1);
         end
      end
   end

   assign row_b      = rd_valid_ff ? ram_rd_data[ROW_W-1:0] : '0;
   assign deg_b      = rd_valid_ff ? ram_rd_data[RAM_W-1:ROW_W] : '0;
   assign inter_b    = ones32(ROW_W'(sides_ff & row_b[MAX_VERTICES-1:0]));
   assign step_delta = $signed({2'b00, deg_b}) - $signed({1'b0, inter_b, 1'b0});
   assign delta_ext  = CUT_W'(step_delta);

   assign gap      = best_ff - cut_ff;
   assign lim_w    = CUT_W'(slack_ff);
   assign sel_w    = CUT_W'(sel_slack_ff);
   assign in_lim   = !gap[CUT_W-1] && (gap <= lim_w);
   assign hit      = c_valid_ff && (gap <= sel_w);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign walking  = (state_ff == S_MAX) || (state_ff == S_HIST) || (state_ff == S_COLLECT);
   assign stall    = (state_ff == S_COLLECT) && hit && !out_free;
   assign scan_sum = {1'b0, acc_ff} + {1'b0, hist_ff[scan_ff]};
   assign cnt_next = cnt_ff + COUNT_W'(1);
   assign best_sat = (best_ff > SAT_LIMIT) ? MAX_W'(MAX_CUT_SAT) : best_ff[MAX_W-1:0];

   always_comb begin
      state_in        = state_ff;
      vcount_in       = vcount_ff;
      pool_in         = pool_ff;
      slack_in        = slack_ff;
      valid_in        = valid_ff;
      issue_active_in = issue_active_ff;
      issue_ctr_in    = issue_ctr_ff;
      b_valid_in      = b_valid_ff;
      b_last_in       = b_last_ff;
      b_vtx_in        = b_vtx_ff;
      rd_valid_in     = rd_valid_ff;
      sides_in        = sides_ff;
      cut_in          = cut_ff;
      c_valid_in      = c_valid_ff;
      c_last_in       = c_last_ff;
      best_in         = best_ff;
      hist_in         = hist_ff;
      scan_in         = scan_ff;
      acc_in          = acc_ff;
      sel_slack_in    = sel_slack_ff;
      cnt_in          = cnt_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_kind_in     = rsp_kind_ff;
      rsp_mask_in     = rsp_mask_ff;
      rsp_max_in      = rsp_max_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_last_in     = rsp_last_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = req_vidx[VA_W-1:0];
      ram_wr_data     = {ones32(req_row), req_row};
      ram_rd_en       = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_VERTEX_COUNT: vcount_in = csr_wr_data;
            CSR_POOL_LIMIT:   pool_in   = csr_wr_data;
            CSR_SLACK_LIMIT:  slack_in  = csr_wr_data[SLACK_W-1:0];
            default:          ;
         endcase
      end

      // advance the step pipeline: issue row read, apply flip, present cut
      if (walking && !stall) begin
         b_valid_in = 1'b0;
         if (issue_active_ff) begin
            ram_rd_en   = 1'b1;
            b_valid_in  = 1'b1;
            b_last_in   = issue_last;
            b_vtx_in    = v_sel;
            rd_valid_in = valid_ff[v_sel];
            if (issue_last) begin
               issue_active_in = 1'b0;
            end else begin
               issue_ctr_in = issue_ctr_ff + CNT_W'(1);
            end
         end
         if (b_valid_ff) begin
            if (sides_ff[b_vtx_ff]) begin
               cut_in             = cut_ff - delta_ext;
               sides_in[b_vtx_ff] = 1'b0;
            end else begin
               cut_in             = cut_ff + delta_ext;
               sides_in[b_vtx_ff] = 1'b1;
            end
         end
         c_valid_in = b_valid_ff;
         c_last_in  = b_last_ff;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == REQ_LOAD) begin
                  if ({1'b0, req_vidx} < NV_MAX) begin
                     ram_wr_en                   = 1'b1;
                     valid_in[req_vidx[VA_W-1:0]] = 1'b1;
                  end
               end else begin
                  best_in         = '0;
                  state_in        = S_MAX;
                  issue_active_in = 1'b1;
                  issue_ctr_in    = CNT_W'(1);
                  b_valid_in      = 1'b0;
                  c_valid_in      = 1'b1;
                  c_last_in       = 1'b0;
                  cut_in          = '0;
                  sides_in        = '0;
               end
            end
         end
         S_MAX: begin
            if (c_valid_ff && (cut_ff > best_ff)) begin
               best_in = cut_ff;
            end
            if (c_valid_ff && c_last_ff) begin
               state_in        = S_HIST;
               issue_active_in = 1'b1;
               issue_ctr_in    = CNT_W'(1);
               b_valid_in      = 1'b0;
               c_valid_in      = 1'b1;
               c_last_in       = 1'b0;
               cut_in          = '0;
               sides_in        = '0;
               for (int e = 0; e < SLACK_SPAN; e++) begin
                  hist_in[e] = '0;
               end
            end
         end
         S_HIST: begin
            for (int e = 0; e < SLACK_SPAN; e++) begin
               if (c_valid_ff && in_lim && (gap[SLACK_W-1:0] == SLACK_W'(e))
                   && (hist_ff[e] != COUNT_W'(MAX_POOL))) begin
                  hist_in[e] = hist_ff[e] + COUNT_W'(1);
               end
            end
            if (c_valid_ff && c_last_ff) begin
               state_in        = S_SCAN;
               scan_in         = '0;
               acc_in          = '0;
               issue_active_in = 1'b0;
               b_valid_in      = 1'b0;
               c_valid_in      = 1'b0;
            end
         end
         S_SCAN: begin
            if ((scan_sum >= {1'b0, pool_k}) || (scan_ff == slack_ff)) begin
               sel_slack_in    = scan_ff;
               cnt_in          = '0;
               state_in        = S_COLLECT;
               issue_active_in = 1'b1;
               issue_ctr_in    = CNT_W'(1);
               b_valid_in      = 1'b0;
               c_valid_in      = 1'b1;
               c_last_in       = 1'b0;
               cut_in          = '0;
               sides_in        = '0;
            end else begin
               scan_in = scan_ff + SLACK_W'(1);
               acc_in  = scan_sum[COUNT_W-1:0];
            end
         end
         S_COLLECT: begin
            if (hit && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_CUT;
               rsp_mask_in  = ROW_W'(sides_ff);
               rsp_max_in   = '0;
               rsp_count_in = '0;
               rsp_last_in  = 1'b0;
               cnt_in       = cnt_next;
            end
            if ((hit && out_free && (cnt_next == pool_k))
                || (c_valid_ff && c_last_ff && !stall)) begin
               state_in        = S_SUMMARY;
               issue_active_in = 1'b0;
               b_valid_in      = 1'b0;
               c_valid_in      = 1'b0;
            end
         end
         S_SUMMARY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_SUMMARY;
               rsp_mask_in  = '0;
               rsp_max_in   = best_sat;
               rsp_count_in = cnt_ff;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         vcount_ff       <= CSR_DATA_W'(32);
         pool_ff         <= COUNT_W'(16);
         slack_ff        <= SLACK_W'(20);
         for (int e = 0; e < MAX_VERTICES; e++) begin
            valid_ff[e] <= 1'b0;
         end
         issue_active_ff <= 1'b0;
         b_valid_ff      <= 1'b0;
         c_valid_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         cnt_ff          <= '0;
      end else begin
         state_ff        <= state_in;
         vcount_ff       <= vcount_in;
         pool_ff         <= pool_in;
         slack_ff        <= slack_in;
         valid_ff        <= valid_in;
         issue_active_ff <= issue_active_in;
         b_valid_ff      <= b_valid_in;
         c_valid_ff      <= c_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         cnt_ff          <= cnt_in;
      end
      issue_ctr_ff <= issue_ctr_in;
      b_last_ff    <= b_last_in;
      b_vtx_ff     <= b_vtx_in;
      rd_valid_ff  <= rd_valid_in;
      sides_ff     <= sides_in;
      cut_ff       <= cut_in;
      c_last_ff    <= c_last_in;
      best_ff      <= best_in;
      hist_ff      <= hist_in;
      scan_ff      <= scan_in;
      acc_ff       <= acc_in;
      sel_slack_ff <= sel_slack_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_mask_ff  <= rsp_mask_in;
      rsp_max_ff   <= rsp_max_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, rsp_max_ff, rsp_mask_ff};

   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!issue_active_ff && !b_valid_ff && !c_valid_ff))
      else $error("step pipeline busy while idle");

   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COLLECT) |-> (cnt_ff < pool_k))
      else $error("collected cuts reached pool limit without leaving collect");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      stall |=> ($stable(issue_ctr_ff) && $stable(cut_ff) && $stable(sides_ff)))
      else $error("walk advanced while a collected cut was held");

   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SUMMARY) && out_free) |=>
         ((state_ff == S_IDLE) && rsp_valid_ff && rsp_last_ff))
      else $error("summary beat not issued on leaving the search");

endmodule

// ===== bench/mcgs_search_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the max-cut Gray-code search unit: follows CSR writes and row loads, predicts
// the cut beats and the summary of every start beat, and compares result beats in order.
// Depends on mcgs_pkg.
module mcgs_search_checker
   import mcgs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   rsp_tuser,
   input  logic                   rsp_tlast,
   output int                     mismatch_count,
   output int                     beats_due
);

   localparam int VERTEX_SLOTS = 32;

   typedef struct {
      logic               kind;
      logic [ROW_W-1:0]   mask;
      logic [MAX_W-1:0]   max_cut;
      logic [COUNT_W-1:0] count;
      logic               last;
   } search_beat_type;

   logic [ROW_W-1:0]   row_store [VERTEX_SLOTS];
   int                 degree_store [VERTEX_SLOTS];
   logic [5:0]         cfg_vertices;
   logic [5:0]         cfg_pool;
   logic [SLACK_W-1:0] cfg_slack;
   logic [ROW_W-1:0]   walk_sides;
   int                 walk_cut;
   search_beat_type    cut_beats [$];

   initial mismatch_count = 0;

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("%0t checker: %s", $time, msg);
   endtask

   // flip the vertex picked by the lowest set bit of the step counter
   function automatic void gray_flip(input longint unsigned step);
      int v;
      int delta;
      v = 0;
      while (v < 63 && step[v] == 1'b0) v++;
      v = v + 1;
      if (v >= VERTEX_SLOTS) return;
      delta = degree_store[v] - 2 * $countones(row_store[v] & walk_sides);
      if (walk_sides[v]) begin
         walk_cut -= delta;
         walk_sides[v] = 1'b0;
      end else begin
         walk_cut += delta;
         walk_sides[v] = 1'b1;
      end
   endfunction

   function automatic void predict_search();
      int              n, pool, lim, slack, cnt, best;
      longint unsigned total, i, acc;
      longint unsigned tally [SLACK_SPAN];
      search_beat_type b;
      n = int'(cfg_vertices);
      if (n < 2) n = 2;
      if (n > VERTEX_SLOTS) n = VERTEX_SLOTS;
      pool = int'(cfg_pool);
      if (pool < 1) pool = 1;
      if (pool > MAX_POOL) pool = MAX_POOL;
      lim = int'(cfg_slack);
      total = 64'd1 << (n - 1);

      walk_sides = '0;
      walk_cut = 0;
      best = 0;
      for (i = 1; i < total; i++) begin
         gray_flip(i);
         if (walk_cut > best) best = walk_cut;
      end

      foreach (tally[j]) tally[j] = 0;
      walk_sides = '0;
      walk_cut = 0;
      if (best <= lim) tally[best]++;
      for (i = 1; i < total; i++) begin
         gray_flip(i);
         if (best - walk_cut >= 0 && best - walk_cut <= lim) tally[best - walk_cut]++;
      end
      slack = lim;
      acc = 0;
      for (int j = 0; j <= lim; j++) begin
         acc += tally[j];
         if (acc >= longint'(pool)) begin
            slack = j;
            break;
         end
      end

      cnt = 0;
      walk_sides = '0;
      walk_cut = 0;
      b.kind = KIND_CUT;
      b.max_cut = '0;
      b.count = '0;
      b.last = 1'b0;
      if (walk_cut >= best - slack) begin
         b.mask = '0;
         cut_beats = {cut_beats, b};
         cnt++;
      end
      for (i = 1; i < total && cnt < pool; i++) begin
         gray_flip(i);
         if (walk_cut >= best - slack) begin
            b.mask = walk_sides;
            cut_beats = {cut_beats, b};
            cnt++;
         end
      end

      b.kind = KIND_SUMMARY;
      b.mask = '0;
      b.max_cut = (best > MAX_CUT_SAT) ? MAX_W'(MAX_CUT_SAT) : MAX_W'(best);
      b.count = COUNT_W'(cnt);
      b.last = 1'b1;
      cut_beats = {cut_beats, b};
   endfunction

   always @(posedge clock) begin : watch
      search_beat_type due;
      if (reset) begin
         foreach (row_store[v]) begin
            row_store[v] = '0;
            degree_store[v] = 0;
         end
         cfg_vertices = 6'd32;
         cfg_pool = 6'd16;
         cfg_slack = 5'd20;
         cut_beats.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_VERTEX_COUNT: cfg_vertices = csr_wr_data;
               CSR_POOL_LIMIT:   cfg_pool = csr_wr_data;
               CSR_SLACK_LIMIT:  cfg_slack = csr_wr_data[SLACK_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == REQ_START) begin
               predict_search();
            end else begin
               row_store[req_tdata[VIDX_W-1:0]] = req_tdata[VIDX_W +: ROW_W];
               degree_store[req_tdata[VIDX_W-1:0]] = $countones(req_tdata[VIDX_W +: ROW_W]);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (cut_beats.size() == 0) begin
               report_mismatch($sformatf("result beat 0x%0h with nothing due", rsp_tdata));
            end else begin
               due = cut_beats.pop_front();
               if (rsp_tuser !== due.kind)
                  report_mismatch($sformatf("result_kind %0b, want %0b", rsp_tuser, due.kind));
               if (rsp_tdata[31:0] !== due.mask)
                  report_mismatch($sformatf("cut_mask 0x%0h, want 0x%0h",
                                            rsp_tdata[31:0], due.mask));
               if (rsp_tdata[40:32] !== due.max_cut)
                  report_mismatch($sformatf("max_cut %0d, want %0d",
                                            rsp_tdata[40:32], due.max_cut));
               if (rsp_tdata[46:41] !== due.count)
                  report_mismatch($sformatf("tight_count %0d, want %0d",
                                            rsp_tdata[46:41], due.count));
               if (rsp_tlast !== due.last)
                  report_mismatch($sformatf("last_result %0b, want %0b", rsp_tlast, due.last));
            end
         end
      end
      beats_due <= cut_beats.size();
   end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Top of the max-cut search unit bench: clock, reset, CSR setup, bursty request stimulus,
// a stalling result sink and the verdict. Depends on mcgs_pkg, the unit and the checker.
module tb;
   import mcgs_pkg::*;

   localparam int ITEM_TARGET   = 370;
   localparam int SETTLE_CYCLES = 16;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;

   int               mismatch_count;
   int               beats_due;
   int               items_sent;
   int               burst_left;
   int               sink_mode;
   int               sink_phase;
   logic [ROW_W-1:0] graph_rows [32];

   max_cut_gray_code_search_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   mcgs_search_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .beats_due      (beats_due)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // result sink: pick a new stall pattern whenever the phase counter runs out
   initial begin
      rsp_tready = 1'b0;
      sink_mode = 0;
      sink_phase = 0;
   end

   always @(negedge clock) begin
      if (sink_phase == 0) begin
         sink_mode <= $urandom_range(0, 3);
         sink_phase <= $urandom_range(16, 96);
      end else begin
         sink_phase <= sink_phase - 1;
      end
      case (sink_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= sink_phase[1] | sink_phase[0];
         default: rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wr_data = CSR_DATA_W'(value);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic send_beat(input logic kind, input int vidx, input logic [ROW_W-1:0] row);
      if (burst_left == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
         burst_left = ($urandom_range(0, 6) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 8);
      end
      req_tuser = kind;
      req_tdata = {3'b000, row, VIDX_W'(vidx)};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      burst_left--;
      items_sent++;
   endtask

   // drop valid, drain every due beat, then let the pipeline empty
   task automatic wait_idle();
      req_tvalid = 1'b0;
      while (beats_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic load_graph(input int n, input int density);
      foreach (graph_rows[v]) graph_rows[v] = '0;
      for (int a = 0; a < n; a++) begin
         for (int b = a + 1; b < n; b++) begin
            if ($urandom_range(0, 99) < density) begin
               graph_rows[a][b] = 1'b1;
               graph_rows[b][a] = 1'b1;
            end
         end
      end
      for (int v = 0; v < n; v++) send_beat(REQ_LOAD, v, graph_rows[v]);
   endtask

   initial begin
      int n, pick;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_VERTEX_COUNT;
      csr_wr_data = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = REQ_LOAD;
      items_sent = 0;
      burst_left = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty graph, limits below range
      write_csr(CSR_VERTEX_COUNT, 0);
      write_csr(CSR_POOL_LIMIT, 0);
      write_csr(CSR_SLACK_LIMIT, 0);
      send_beat(REQ_START, 0, '0);
      wait_idle();

      // complete graph on four vertices, widest pool and slack
      write_csr(CSR_VERTEX_COUNT, 4);
      write_csr(CSR_POOL_LIMIT, MAX_POOL);
      write_csr(CSR_SLACK_LIMIT, 31);
      send_beat(REQ_LOAD, 0, 32'h0000_000E);
      send_beat(REQ_LOAD, 1, 32'h0000_000D);
      send_beat(REQ_LOAD, 2, 32'h0000_000B);
      send_beat(REQ_LOAD, 3, 32'h0000_0007);
      send_beat(REQ_START, 31, '1);

      // top vertex full row, a self loop, a one-sided edge
      send_beat(REQ_LOAD, 31, '1);
      send_beat(REQ_LOAD, 1, 32'h0000_0003);
      send_beat(REQ_LOAD, 3, 32'h0000_0000);
      send_beat(REQ_START, 0, '0);
      wait_idle();

      // largest vertex counts written while idle, then dense odd rows that saturate
      write_csr(CSR_VERTEX_COUNT, 63);
      write_csr(CSR_VERTEX_COUNT, 32);
      write_csr(CSR_VERTEX_COUNT, 12);
      for (int v = 0; v < 12; v++) send_beat(REQ_LOAD, v, '1);
      send_beat(REQ_START, 0, '0);
      wait_idle();

      while (items_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         n = (pick < 70) ? $urandom_range(2, 8) : (pick < 95) ? $urandom_range(9, 11) : 12;
         write_csr(CSR_VERTEX_COUNT, (n == 2 && $urandom_range(0, 1)) ? $urandom_range(0, 1) : n);
         pick = $urandom_range(0, 99);
         write_csr(CSR_POOL_LIMIT, (pick < 10) ? MAX_POOL : (pick < 15) ? 0
                                                : $urandom_range(1, MAX_POOL));
         pick = $urandom_range(0, 99);
         write_csr(CSR_SLACK_LIMIT, (pick < 15) ? 0 : (pick < 25) ? 31 : $urandom_range(0, 31));
         repeat ($urandom_range(1, 2)) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
               load_graph(n, $urandom_range(10, 90));
            end else if (pick < 90) begin
               repeat ($urandom_range(1, n))
                  send_beat(REQ_LOAD, $urandom_range(0, n - 1), $urandom());
            end
            if ($urandom_range(0, 4) == 0) begin
               repeat ($urandom_range(1, 3))
                  send_beat(REQ_LOAD, $urandom_range(0, 31), $urandom());
            end
            send_beat(REQ_START, $urandom_range(0, 31), $urandom());
         end
         wait_idle();
      end

      if (mismatch_count == 0 && beats_due == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/mcgs_pkg.sv
rtl/core/mcgs_ram.sv
rtl/core/max_cut_gray_code_search_unit.sv
bench/mcgs_search_checker.sv
bench/tb.sv
